// File: design/ict_pkg.sv
// Shared types, codes and defaults for the interval coverage tracker.
`timescale 1ns / 1ps

package ict_pkg;

	// Default number of interval slots.
	localparam int SEGMENT_SLOTS_DEF = 64;

	// Width of times and of the configuration data bus.
	localparam int TIME_W = 64;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_OPEN  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_CLOSED = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_CLOSE = 2'd2;

	// Item kinds.
	localparam logic KIND_ADD   = 1'b0;
	localparam logic KIND_CHECK = 1'b1;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_OVERLAP = 2'd2,
		ST_HOLE    = 2'd3
	} status_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_INSERT
	} state_t;

	// One stored interval, raw bits of two signed times.
	typedef struct packed {
		logic [TIME_W-1:0] first_ns;
		logic [TIME_W-1:0] end_ns;
	} entry_t;

endpackage

// File: design/ict_store.sv
// Interval store: one write port, one registered read port.
`timescale 1ns / 1ps

module ict_store #(
	parameter int DEPTH = ict_pkg::SEGMENT_SLOTS_DEF,
	parameter int AW = $clog2(DEPTH)
) (
	input  logic           clk,
	input  logic           we,
	input  logic [AW-1:0]  waddr,
	input  ict_pkg::entry_t wdata,
	input  logic           re,
	input  logic [AW-1:0]  raddr,
	output ict_pkg::entry_t rdata
);
	import ict_pkg::*;

	entry_t mem_q [DEPTH];
	entry_t rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: design/ict_cmp.sv
// Shared compare unit: three signed less-than lanes on 64-bit times.
`timescale 1ns / 1ps

module ict_cmp (
	input  logic signed [ict_pkg::TIME_W-1:0] a0,
	input  logic signed [ict_pkg::TIME_W-1:0] b0,
	input  logic signed [ict_pkg::TIME_W-1:0] a1,
	input  logic signed [ict_pkg::TIME_W-1:0] b1,
	input  logic signed [ict_pkg::TIME_W-1:0] a2,
	input  logic signed [ict_pkg::TIME_W-1:0] b2,
	output logic                              lt0,
	output logic                              lt1,
	output logic                              lt2
);
	import ict_pkg::*;

	// Each lane answers a < b.
	assign lt0 = (a0 < b0);
	assign lt1 = (a1 < b1);
	assign lt2 = (a2 < b2);

endmodule

// File: design/interval_coverage_tracker.sv
// Top level: sequencer, registers and result logic of the interval coverage tracker.
//
// Channel   Direction  Handshake               Payload
// command   in         start & !busy           kind, seg_start_ns, seg_end_ns, check_until_ns,
//                                              session_complete
// result    out        done, one cycle         status, hole_start_ns, hole_end_ns
// config    in         cfg_we                  cfg_index, cfg_data
//
// An add on a full table answers without a walk. Otherwise the store is walked one
// entry per cycle through the shared compare unit, stopping early when a hole or an
// overlap ends the walk; an add then moves entries up to open the insert slot, each
// with a read step and a write step, and writes the new entry in a last step.
// The result beat appears in the same cycle as busy drops; for a full add busy stays low.
// Reset clears the count and the window registers; the store needs no clearing.
// The receiver cannot stall: each result beat is shown for exactly one cycle.
`timescale 1ns / 1ps

module interval_coverage_tracker #(
	parameter int SEGMENT_SLOTS = ict_pkg::SEGMENT_SLOTS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic                                kind,
	input  logic signed [ict_pkg::TIME_W-1:0]   seg_start_ns,
	input  logic signed [ict_pkg::TIME_W-1:0]   seg_end_ns,
	input  logic signed [ict_pkg::TIME_W-1:0]   check_until_ns,
	input  logic                                session_complete,
	output logic                                done,
	output logic [1:0]                          status,
	output logic signed [ict_pkg::TIME_W-1:0]   hole_start_ns,
	output logic signed [ict_pkg::TIME_W-1:0]   hole_end_ns,
	input  logic                                cfg_we,
	input  logic [ict_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ict_pkg::TIME_W-1:0]          cfg_data
);
	import ict_pkg::*;

	localparam int AW = $clog2(SEGMENT_SLOTS);
	localparam int CW = $clog2(SEGMENT_SLOTS + 1);

	state_t state_q, state_d;

	// Configuration registers.
	logic signed [TIME_W-1:0] win_open_q;
	logic                     win_closed_q;
	logic signed [TIME_W-1:0] win_close_q;

	// Item and walk registers.
	logic [CW-1:0]            count_q;
	logic                     kind_q;
	logic                     complete_q;
	logic signed [TIME_W-1:0] s_q;
	logic signed [TIME_W-1:0] e_q;
	logic signed [TIME_W-1:0] end_q;
	logic signed [TIME_W-1:0] cursor_q;
	logic [CW-1:0]            idx_q;
	logic [AW-1:0]            pos_q;
	logic                     found_q;
	logic [AW-1:0]            wp_q;
	logic                     vld_s1;
	logic [AW-1:0]            addr_s1;

	// Result registers.
	logic                     done_q;
	status_t                  status_q;
	logic signed [TIME_W-1:0] hole_start_q;
	logic signed [TIME_W-1:0] hole_end_q;

	// Store ports.
	logic          mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr;
	entry_t        mem_wdata, mem_rdata;
	logic signed [TIME_W-1:0] rd_start, rd_end;

	// Compare unit operands.
	logic signed [TIME_W-1:0] a0, b0, a1, b1, a2, b2;
	logic lt0, lt1, lt2;

	// Walk flags.
	logic accept, full, scan_eval, add_ovl, chk_gap, scan_stop, scan_end, rd_issue;

	ict_store #(
		.DEPTH (SEGMENT_SLOTS),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	ict_cmp u_cmp (
		.a0  (a0),
		.b0  (b0),
		.a1  (a1),
		.b1  (b1),
		.a2  (a2),
		.b2  (b2),
		.lt0 (lt0),
		.lt1 (lt1),
		.lt2 (lt2)
	);

	assign rd_start = $signed(mem_rdata.first_ns);
	assign rd_end   = $signed(mem_rdata.end_ns);

	// Operand selection for the shared compare unit.
	always_comb begin
		if (kind_q == KIND_ADD) begin
			a0 = s_q;      b0 = rd_end;
			a1 = rd_start; b1 = e_q;
			a2 = s_q;      b2 = rd_start;
		end else begin
			a0 = cursor_q; b0 = rd_start;
			a1 = cursor_q; b1 = rd_end;
			a2 = cursor_q; b2 = end_q;
		end
		// While idle, lane two clips the check end against the close time.
		if (state_q == S_IDLE) begin
			a2 = win_close_q;
			b2 = check_until_ns;
		end
	end

	// Walk decisions.
	assign accept    = start && (state_q == S_IDLE);
	assign full      = (count_q == CW'(SEGMENT_SLOTS));
	assign scan_eval = (state_q == S_SCAN) && vld_s1;
	assign add_ovl   = scan_eval && (kind_q == KIND_ADD) && lt0 && lt1;
	assign chk_gap   = scan_eval && (kind_q == KIND_CHECK) && lt0;
	assign scan_stop = add_ovl || chk_gap;
	assign scan_end  = (state_q == S_SCAN) && !vld_s1 && (idx_q == count_q);
	assign rd_issue  = (state_q == S_SCAN) && !scan_stop && (idx_q < count_q);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && !((kind == KIND_ADD) && full)) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (scan_stop) begin
					state_d = S_IDLE;
				end else if (scan_end) begin
					if (kind_q == KIND_CHECK) begin
						state_d = S_IDLE;
					end else if (wp_q == pos_q) begin
						state_d = S_INSERT;
					end else begin
						state_d = S_SHIFT_RD;
					end
				end
			end
			S_SHIFT_RD: begin
				state_d = S_SHIFT_WR;
			end
			S_SHIFT_WR: begin
				if ((wp_q - AW'(1)) == pos_q) begin
					state_d = S_INSERT;
				end else begin
					state_d = S_SHIFT_RD;
				end
			end
			S_INSERT: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Store control.
	always_comb begin
		mem_re    = rd_issue || (state_q == S_SHIFT_RD);
		mem_raddr = (state_q == S_SHIFT_RD) ? (wp_q - AW'(1)) : idx_q[AW-1:0];
		mem_we    = (state_q == S_SHIFT_WR) || (state_q == S_INSERT);
		mem_waddr = (state_q == S_SHIFT_WR) ? wp_q : pos_q;
		if (state_q == S_SHIFT_WR) begin
			mem_wdata = mem_rdata;
		end else begin
			mem_wdata.first_ns = s_q;
			mem_wdata.end_ns   = e_q;
		end
	end

	// Control state and configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			vld_s1       <= 1'b0;
			done_q       <= 1'b0;
			win_open_q   <= '0;
			win_closed_q <= 1'b0;
			win_close_q  <= '0;
		end else begin
			state_q <= state_d;
			vld_s1  <= rd_issue;
			done_q  <= (accept && (kind == KIND_ADD) && full) || scan_stop
				|| (scan_end && (kind_q == KIND_CHECK)) || (state_q == S_INSERT);
			if (state_q == S_INSERT) begin
				count_q <= count_q + CW'(1);
			end
			if (cfg_we) begin
				if (cfg_index == REG_WINDOW_OPEN) begin
					win_open_q <= $signed(cfg_data);
				end else if (cfg_index == REG_WINDOW_CLOSED) begin
					win_closed_q <= cfg_data[0];
				end else if (cfg_index == REG_WINDOW_CLOSE) begin
					win_close_q <= $signed(cfg_data);
				end
			end
		end
	end

	// Walk datapath registers.
	always_ff @(posedge clk) begin
		addr_s1 <= idx_q[AW-1:0];
		if (accept) begin
			kind_q     <= kind;
			complete_q <= session_complete;
			s_q        <= seg_start_ns;
			e_q        <= seg_end_ns;
			end_q      <= (win_closed_q && lt2) ? win_close_q : check_until_ns;
			cursor_q   <= win_open_q;
			idx_q      <= '0;
			pos_q      <= count_q[AW-1:0];
			wp_q       <= count_q[AW-1:0];
			found_q    <= 1'b0;
		end
		if (rd_issue) begin
			idx_q <= idx_q + CW'(1);
		end
		if (scan_eval) begin
			if (kind_q == KIND_ADD) begin
				if (!found_q && lt2) begin
					pos_q   <= addr_s1;
					found_q <= 1'b1;
				end
			end else if (!lt0 && lt1) begin
				cursor_q <= rd_end;
			end
		end
		if (state_q == S_SHIFT_WR) begin
			wp_q <= wp_q - AW'(1);
		end
	end

	// Result registers, held from one beat to the next.
	always_ff @(posedge clk) begin
		if (accept && (kind == KIND_ADD) && full) begin
			status_q     <= ST_FULL;
			hole_start_q <= '0;
			hole_end_q   <= '0;
		end else if (add_ovl) begin
			status_q     <= ST_OVERLAP;
			hole_start_q <= '0;
			hole_end_q   <= '0;
		end else if (chk_gap) begin
			status_q     <= ST_HOLE;
			hole_start_q <= cursor_q;
			hole_end_q   <= rd_start;
		end else if (scan_end && (kind_q == KIND_CHECK)) begin
			if (lt2 && complete_q) begin
				status_q     <= ST_HOLE;
				hole_start_q <= cursor_q;
				hole_end_q   <= end_q;
			end else begin
				status_q     <= ST_OK;
				hole_start_q <= '0;
				hole_end_q   <= '0;
			end
		end else if (state_q == S_INSERT) begin
			status_q     <= ST_OK;
			hole_start_q <= '0;
			hole_end_q   <= '0;
		end
	end

	// Ports.
	assign busy          = (state_q != S_IDLE);
	assign done          = done_q;
	assign status        = status_q;
	assign hole_start_ns = hole_start_q;
	assign hole_end_ns   = hole_end_q;

	// A result beat only appears once the sequencer is back at rest.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while busy");

	// The table never holds more intervals than it has slots.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(SEGMENT_SLOTS))
		else $error("interval count beyond slot count");

	// The count only grows together with an accepted add.
	a_count_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> (done && (status_q == ST_OK)
			&& (count_q == $past(count_q) + CW'(1))))
		else $error("count changed without an accepted add");

	// An accepted item either starts a walk or answers at once.
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted item neither walked nor answered");

endmodule

// File: sim/tb.sv
// Self-checking testbench for the interval coverage tracker: directed table, then random traffic.
`timescale 1ns / 1ps

module tb;
	import ict_pkg::*;

	localparam int SLOTS = SEGMENT_SLOTS_DEF;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE = 8;
	localparam int PITCH = 100;
	localparam int REGION_SLOTS = 128;
	localparam int ITEMS_PER_PHASE = 217;
	localparam int ITEMS_PER_WINDOW = 40;

	typedef logic signed [TIME_W-1:0] ns_t;

	localparam ns_t T_MIN = {1'b1, {(TIME_W-1){1'b0}}};
	localparam ns_t T_MAX = {1'b0, {(TIME_W-1){1'b1}}};

	typedef struct packed {
		status_t status;
		ns_t     hole_start;
		ns_t     hole_end;
	} answer_t;

	typedef enum logic {
		ROW_ITEM,
		ROW_REG
	} row_op_t;

	// One step of stimulus: a command beat or a register write (data in s).
	typedef struct {
		row_op_t               op;
		logic [CFG_IDX_W-1:0]  idx;
		logic                  kind;
		ns_t                   s;
		ns_t                   e;
		ns_t                   up;
		logic                  comp;
		bit                    typed;
		answer_t               want;
	} row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	logic                 kind = KIND_ADD;
	ns_t                  seg_start_ns = '0;
	ns_t                  seg_end_ns = '0;
	ns_t                  check_until_ns = '0;
	logic                 session_complete = 1'b0;
	logic                 done;
	logic [1:0]           status;
	ns_t                  hole_start_ns;
	ns_t                  hole_end_ns;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_WINDOW_OPEN;
	logic [TIME_W-1:0]    cfg_data = '0;

	// Shadow copy of the interval table and window registers.
	ns_t     tbl_start [SLOTS];
	ns_t     tbl_end [SLOTS];
	int      tbl_count = 0;
	ns_t     open_ns = '0;
	logic    closed_flag = 1'b0;
	ns_t     close_ns = '0;

	answer_t pending_answers [$];
	row_t    plan [$];
	int      errors = 0;
	int      cycles = 0;
	int      items_sent = 0;
	int      reg_writes = 0;
	int      idle_pct = 0;
	int      seen_by_status [4] = '{0, 0, 0, 0};

	interval_coverage_tracker i_dut (.*);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic ns_t rand_ns();
		return {$urandom, $urandom};
	endfunction

	// Works out the answer to one command and updates the shadow table.
	function automatic answer_t tracker_answer(logic k, ns_t s, ns_t e, ns_t up, logic comp);
		answer_t ans;
		ns_t     stop;
		ns_t     cursor;
		int      pos;
		int      i;
		ans.status = ST_OK;
		ans.hole_start = '0;
		ans.hole_end = '0;
		if (k == KIND_ADD) begin
			if (tbl_count >= SLOTS) begin
				ans.status = ST_FULL;
				return ans;
			end
			for (i = 0; i < tbl_count; i++) begin
				if (s < tbl_end[i] && tbl_start[i] < e) begin
					ans.status = ST_OVERLAP;
					return ans;
				end
			end
			// Insert after any entry with the same start.
			pos = tbl_count;
			for (i = tbl_count - 1; i >= 0; i--) begin
				if (s < tbl_start[i])
					pos = i;
			end
			for (i = tbl_count; i > pos; i--) begin
				tbl_start[i] = tbl_start[i-1];
				tbl_end[i] = tbl_end[i-1];
			end
			tbl_start[pos] = s;
			tbl_end[pos] = e;
			tbl_count++;
			return ans;
		end
		// Coverage walk: the end is clipped by the close time when one is set.
		stop = up;
		if (closed_flag && close_ns < stop)
			stop = close_ns;
		cursor = open_ns;
		for (i = 0; i < tbl_count; i++) begin
			if (tbl_start[i] > cursor) begin
				ans.status = ST_HOLE;
				ans.hole_start = cursor;
				ans.hole_end = tbl_start[i];
				return ans;
			end
			if (tbl_end[i] > cursor)
				cursor = tbl_end[i];
		end
		if (cursor < stop && comp) begin
			ans.status = ST_HOLE;
			ans.hole_start = cursor;
			ans.hole_end = stop;
		end
		return ans;
	endfunction

	task automatic plan_item(logic k, ns_t s, ns_t e, ns_t up, logic comp,
			bit typed, status_t st, ns_t hs, ns_t he);
		row_t r;
		r.op = ROW_ITEM;
		r.idx = REG_WINDOW_OPEN;
		r.kind = k;
		r.s = s;
		r.e = e;
		r.up = up;
		r.comp = comp;
		r.typed = typed;
		r.want.status = st;
		r.want.hole_start = hs;
		r.want.hole_end = he;
		plan.push_back(r);
	endtask

	task automatic plan_reg(logic [CFG_IDX_W-1:0] idx, ns_t data);
		row_t r;
		r.op = ROW_REG;
		r.idx = idx;
		r.kind = KIND_ADD;
		r.s = data;
		r.e = '0;
		r.up = '0;
		r.comp = 1'b0;
		r.typed = 1'b0;
		r.want.status = ST_OK;
		r.want.hole_start = '0;
		r.want.hole_end = '0;
		plan.push_back(r);
	endtask

	// Drops start and waits until every answer has arrived and the block has settled.
	task automatic wait_idle();
		start <= 1'b0;
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [TIME_W-1:0] data);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_WINDOW_OPEN: open_ns = data;
			REG_WINDOW_CLOSED: closed_flag = data[0];
			REG_WINDOW_CLOSE: close_ns = data;
			default: ;
		endcase
		reg_writes++;
		@(posedge clk);
	endtask

	// Offers one command beat and records its expected answer once it is taken.
	// Start is left high so that a following beat can go out without a gap.
	task automatic send_item(row_t r);
		answer_t got;
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < idle_pct)
				@(posedge clk);
		end
		start <= 1'b1;
		kind <= r.kind;
		seg_start_ns <= r.s;
		seg_end_ns <= r.e;
		check_until_ns <= r.up;
		session_complete <= r.comp;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		got = tracker_answer(r.kind, r.s, r.e, r.up, r.comp);
		pending_answers.push_back(r.typed ? r.want : got);
		items_sent++;
	endtask

	// Compare each result beat with the oldest outstanding answer.
	always @(posedge clk) begin : result_check
		answer_t want;
		if (arst_n && done) begin
			if (pending_answers.size() == 0) begin
				$error("result beat with nothing outstanding: status %0d", status);
				errors++;
			end else begin
				want = pending_answers.pop_front();
				seen_by_status[want.status]++;
				if (status !== want.status) begin
					$error("field status: expected %0d, got %0d", want.status, status);
					errors++;
				end
				if (hole_start_ns !== want.hole_start) begin
					$error("field hole_start_ns: expected %0d, got %0d",
						want.hole_start, hole_start_ns);
					errors++;
				end
				if (hole_end_ns !== want.hole_end) begin
					$error("field hole_end_ns: expected %0d, got %0d",
						want.hole_end, hole_end_ns);
					errors++;
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("cycle limit reached with %0d answers outstanding",
				pending_answers.size());
			$display("status: fail");
			$finish;
		end
	end

	initial begin : stimulus
		row_t r;
		ns_t  base;
		int   pick;
		int   a;
		int   b;

		// Empty table: a complete session leaves one tail hole up to a later end, otherwise clean.
		plan_item(KIND_CHECK, '0, '0, 100, 1'b1, 1, ST_HOLE, 0, 100);
		plan_item(KIND_CHECK, '0, '0, T_MAX, 1'b0, 1, ST_OK, 0, 0);
		plan_item(KIND_CHECK, '0, '0, T_MIN, 1'b1, 1, ST_OK, 0, 0);
		// Adds: overlap, touching ends, empty and reversed intervals, equal starts.
		plan_item(KIND_ADD, 10, 20, '0, 1'b0, 1, ST_OK, 0, 0);
		plan_item(KIND_ADD, 15, 25, '0, 1'b0, 1, ST_OVERLAP, 0, 0);
		plan_item(KIND_ADD, 20, 30, '0, 1'b0, 0, ST_OK, 0, 0);
		plan_item(KIND_ADD, 0, 10, '0, 1'b0, 0, ST_OK, 0, 0);
		plan_item(KIND_CHECK, '0, '0, 30, 1'b1, 0, ST_OK, 0, 0);
		plan_item(KIND_CHECK, '0, '0, 50, 1'b1, 0, ST_OK, 0, 0);
		plan_item(KIND_ADD, 40, 40, '0, 1'b0, 0, ST_OK, 0, 0);
		plan_item(KIND_ADD, 60, 55, '0, 1'b0, 0, ST_OK, 0, 0);
		plan_item(KIND_ADD, 35, 45, '0, 1'b0, 0, ST_OK, 0, 0);
		plan_item(KIND_ADD, 10, 10, '0, 1'b0, 0, ST_OK, 0, 0);
		plan_item(KIND_ADD, T_MIN, T_MIN + 5, '0, 1'b0, 0, ST_OK, 0, 0);
		plan_item(KIND_CHECK, '0, '0, T_MAX, 1'b1, 0, ST_OK, 0, 0);
		// Window open past the table, close time clipping the tail hole.
		plan_reg(REG_WINDOW_OPEN, 100);
		plan_reg(REG_WINDOW_CLOSED, 1);
		plan_reg(REG_WINDOW_CLOSE, 150);
		plan_item(KIND_CHECK, '0, '0, T_MAX, 1'b1, 0, ST_OK, 0, 0);
		plan_item(KIND_CHECK, '0, '0, 120, 1'b1, 0, ST_OK, 0, 0);
		plan_item(KIND_CHECK, '0, '0, T_MAX, 1'b0, 0, ST_OK, 0, 0);
		// Close time below the open time.
		plan_reg(REG_WINDOW_CLOSE, 50);
		plan_item(KIND_CHECK, '0, '0, T_MAX, 1'b1, 0, ST_OK, 0, 0);
		plan_reg(REG_WINDOW_CLOSED, 0);
		plan_item(KIND_CHECK, '0, '0, T_MAX, 1'b1, 0, ST_OK, 0, 0);
		plan_item(KIND_ADD, T_MAX - 5, T_MAX, '0, 1'b0, 0, ST_OK, 0, 0);
		plan_item(KIND_CHECK, '0, '0, T_MAX, 1'b1, 0, ST_OK, 0, 0);
		plan_reg(REG_WINDOW_OPEN, T_MIN);
		plan_item(KIND_CHECK, '0, '0, T_MAX, 1'b1, 0, ST_OK, 0, 0);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].op == ROW_REG)
				write_reg(plan[i].idx, plan[i].s);
			else
				send_item(plan[i]);
		end

		// Random traffic lives mostly in a grid of slots above a random base.
		base = rand_ns();
		if (base > T_MAX - 20000)
			base = base - 20000;
		r.op = ROW_ITEM;
		r.idx = REG_WINDOW_OPEN;
		r.typed = 1'b0;
		r.want.status = ST_OK;
		r.want.hole_start = '0;
		r.want.hole_end = '0;

		for (int ph = 0; ph < 3; ph++) begin
			idle_pct = (ph == 0) ? 23 : (ph == 1) ? 79 : 0;
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// New window settings every few dozen beats.
				if (n % ITEMS_PER_WINDOW == 0) begin
					pick = $urandom_range(9);
					if (pick < 7)
						write_reg(REG_WINDOW_OPEN,
							base + $urandom_range(REGION_SLOTS) * PITCH);
					else if (pick == 7)
						write_reg(REG_WINDOW_OPEN, T_MIN);
					else if (pick == 8)
						write_reg(REG_WINDOW_OPEN, T_MAX);
					else
						write_reg(REG_WINDOW_OPEN, rand_ns());
					write_reg(REG_WINDOW_CLOSED, $urandom_range(1));
					pick = $urandom_range(9);
					if (pick < 7)
						write_reg(REG_WINDOW_CLOSE,
							base + $urandom_range(REGION_SLOTS * PITCH));
					else if (pick == 7)
						write_reg(REG_WINDOW_CLOSE, T_MIN);
					else if (pick == 8)
						write_reg(REG_WINDOW_CLOSE, T_MAX);
					else
						write_reg(REG_WINDOW_CLOSE, rand_ns());
				end

				pick = $urandom_range(99);
				r.comp = $urandom_range(1);
				if (pick < 45) begin
					// Well-formed interval inside one grid slot, often the whole slot.
					r.kind = KIND_ADD;
					if ($urandom_range(99) < 60) begin
						a = 0;
						b = PITCH;
					end else begin
						a = $urandom_range(PITCH - 1);
						b = $urandom_range(PITCH, a + 1);
					end
					r.s = base + $urandom_range(REGION_SLOTS - 1) * PITCH + a;
					r.e = r.s + (b - a);
					r.up = rand_ns();
				end else if (pick < 55) begin
					r.kind = KIND_ADD;
					r.s = rand_ns();
					r.e = rand_ns();
					r.up = rand_ns();
				end else if (pick < 90) begin
					r.kind = KIND_CHECK;
					r.s = rand_ns();
					r.e = rand_ns();
					r.up = base + $urandom_range(REGION_SLOTS * PITCH + PITCH);
				end else begin
					r.kind = KIND_CHECK;
					r.s = rand_ns();
					r.e = rand_ns();
					r.up = rand_ns();
				end
				send_item(r);
			end
		end

		wait_idle();
		$display("%0d command beats, %0d register writes, %0d intervals stored",
			items_sent, reg_writes, tbl_count);
		$display("answers seen: %0d ok, %0d full, %0d overlap, %0d hole",
			seen_by_status[ST_OK], seen_by_status[ST_FULL],
			seen_by_status[ST_OVERLAP], seen_by_status[ST_HOLE]);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// File: interval_coverage_tracker.f
design/ict_pkg.sv
design/ict_store.sv
design/ict_cmp.sv
design/interval_coverage_tracker.sv
sim/tb.sv
